// ----- hdl/ogpe_pkg.sv -----
// ----------------------------------------------------------------------------
// ogpe_pkg
// Shared constants and types for the ogive profile point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package ogpe_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_BITS_DEF = 32;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_CFG   = 2'd1;
   localparam logic [1:0] STATUS_OFF_CURVE = 2'd2;
   localparam logic [1:0] STATUS_INF_SLOPE = 2'd3;

   localparam logic REG_RHO  = 1'b0;
   localparam logic REG_DIAM = 1'b1;

   typedef struct packed {
      logic busy;
      logic length_valid;
   } cfg_status_type;

endpackage

`default_nettype wire

// ----- hdl/ogpe_if.sv -----
// ----------------------------------------------------------------------------
// ogpe_if
// Valid/ready channels for axial positions and profile points.
// ----------------------------------------------------------------------------
`default_nettype none

interface ogpe_req_if #(parameter int WORD_BITS = 32);
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] x;
   modport source (output valid, output x, input ready);
   modport sink   (input valid, input x, output ready);
endinterface

interface ogpe_rsp_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS:0]   y;
   logic signed [WORD_BITS-1:0] slope;
   logic [1:0]                  status;
   modport source (output valid, output y, output slope, output status, input ready);
   modport sink   (input valid, input y, input slope, input status, output ready);
endinterface

`default_nettype wire

// ----- hdl/ogpe_cfg.sv -----
// ----------------------------------------------------------------------------
// ogpe_cfg
// CSR block; derives ogive length L and rho^2 after every write.
// ----------------------------------------------------------------------------
`default_nettype none

module ogpe_cfg #(
   parameter int WORD_BITS = ogpe_pkg::WORD_BITS_DEF,
   parameter int AW        = 3,
   parameter int DW        = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [AW-1:0]          csr_paddr,
   input  wire logic [DW-1:0]          csr_pwdata,
   output logic [DW-1:0]               csr_prdata,
   output logic                        csr_pready,
   output logic [WORD_BITS-1:0]        rho,
   output logic [WORD_BITS-1:0]        diam,
   output logic [WORD_BITS-1:0]        len,
   output logic [2*WORD_BITS-1:0]      rr,
   output ogpe_pkg::cfg_status_type    status
);
   import ogpe_pkg::*;

   localparam int K  = WORD_BITS + 1;
   localparam int RW = K + 3;
   localparam int CW = $clog2(K);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ROOT} state_type;

   state_type              state_ff;
   logic [WORD_BITS-1:0]   rho_ff, diam_ff, len_ff;
   logic [2*WORD_BITS-1:0] rr_ff;
   logic                   valid_ff;
   logic [2*K-1:0]         p_ff;
   logic [RW-1:0]          rem_ff;
   logic [K-1:0]           root_ff;
   logic [CW-1:0]          cnt_ff;

   logic                   wr, idx;
   logic [WORD_BITS+1:0]   four_rho, diff;
   logic [2*WORD_BITS+3:0] prod_full;
   logic [2*WORD_BITS-1:0] rr_in;
   logic [RW-1:0]          rem_sh, trial;
   logic                   ge;
   logic [K-1:0]           root_in;

   assign wr        = csr_psel & csr_penable & csr_pwrite;
   assign idx       = csr_paddr[AW-1];
   assign four_rho  = {rho_ff, 2'b00};
   assign diff      = four_rho - {2'b00, diam_ff};
   assign prod_full = {4'b0000, diam_ff} * {2'b00, diff};
   assign rr_in     = {{WORD_BITS{1'b0}}, rho_ff} * {{WORD_BITS{1'b0}}, rho_ff};
   assign rem_sh    = {rem_ff[RW-3:0], p_ff[2*K-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign ge        = rem_sh >= trial;
   assign root_in   = {root_ff[K-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rho_ff   <= '0;
         diam_ff  <= '0;
         len_ff   <= '0;
         rr_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (wr) begin
            if (idx == REG_RHO) begin
               rho_ff <= csr_pwdata[WORD_BITS-1:0];
            end else begin
               diam_ff <= csr_pwdata[WORD_BITS-1:0];
            end
            state_ff <= ST_MUL;
         end else begin
            case (state_ff)
               ST_MUL: begin
                  valid_ff <= four_rho >= {2'b00, diam_ff};
                  p_ff     <= (four_rho >= {2'b00, diam_ff}) ? prod_full[2*K-1:0] : '0;
                  rr_ff    <= rr_in;
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= CW'(K - 1);
                  state_ff <= ST_ROOT;
               end
               ST_ROOT: begin
                  p_ff    <= p_ff << 2;
                  rem_ff  <= ge ? rem_sh - trial : rem_sh;
                  root_ff <= root_in;
                  cnt_ff  <= cnt_ff - 1'b1;
                  if (cnt_ff == '0) begin
                     len_ff   <= valid_ff ? root_in[K-1:1] : '0;
                     state_ff <= ST_IDLE;
                  end
               end
               default: state_ff <= ST_IDLE;
            endcase
         end
      end
   end

   always_comb begin
      case (idx)
         REG_RHO: csr_prdata = DW'(rho_ff);
         default: csr_prdata = DW'(diam_ff);
      endcase
   end

   assign csr_pready          = 1'b1;
   assign rho                 = rho_ff;
   assign diam                = diam_ff;
   assign len                 = len_ff;
   assign rr                  = rr_ff;
   assign status.busy         = state_ff != ST_IDLE;
   assign status.length_valid = valid_ff;

endmodule

`default_nettype wire

// ----- hdl/ogpe_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// ogpe_sqrt_pipe
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ogpe_sqrt_pipe #(
   parameter int K      = 33,
   parameter int SIDE_W = 35
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [2*K-1:0]    in_rad,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [K-1:0]           out_root,
   output logic [SIDE_W-1:0]      out_side
);
   localparam int RW = K + 3;

   logic              v_ff    [K];
   logic [2*K-1:0]    rad_ff  [K];
   logic [RW-1:0]     rem_ff  [K];
   logic [K-1:0]      root_ff [K];
   logic [SIDE_W-1:0] side_ff [K];

   for (genvar i = 0; i < K; i++) begin : g_stage
      logic              pv;
      logic [2*K-1:0]    prad;
      logic [RW-1:0]     prem, rem_sh, trial;
      logic [K-1:0]      proot;
      logic [SIDE_W-1:0] pside;
      logic              ge;

      if (i == 0) begin : g_first
         assign pv    = in_valid;
         assign prad  = in_rad;
         assign prem  = '0;
         assign proot = '0;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = v_ff[i-1];
         assign prad  = rad_ff[i-1];
         assign prem  = rem_ff[i-1];
         assign proot = root_ff[i-1];
         assign pside = side_ff[i-1];
      end

      assign rem_sh = {prem[RW-3:0], prad[2*K-1 -: 2]};
      assign trial  = {1'b0, proot, 2'b01};
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= pv;
         end
         if (en) begin
            rad_ff[i]  <= prad << 2;
            rem_ff[i]  <= ge ? rem_sh - trial : rem_sh;
            root_ff[i] <= {proot[K-2:0], ge};
            side_ff[i] <= pside;
         end
      end
   end

   assign out_valid = v_ff[K-1];
   assign out_root  = root_ff[K-1];
   assign out_side  = side_ff[K-1];

endmodule

`default_nettype wire

// ----- hdl/ogpe_div_pipe.sv -----
// ----------------------------------------------------------------------------
// ogpe_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ogpe_div_pipe #(
   parameter int NB     = 49,
   parameter int DB     = 33,
   parameter int SIDE_W = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [NB-1:0]     in_num,
   input  wire logic [DB-1:0]     in_dv,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [NB-1:0]          out_q,
   output logic [DB-1:0]          out_dv,
   output logic [SIDE_W-1:0]      out_side
);
   logic              v_ff    [NB];
   logic [NB-1:0]     num_ff  [NB];
   logic [DB:0]       rem_ff  [NB];
   logic [NB-1:0]     q_ff    [NB];
   logic [DB-1:0]     dv_ff   [NB];
   logic [SIDE_W-1:0] side_ff [NB];

   for (genvar i = 0; i < NB; i++) begin : g_stage
      logic              pv;
      logic [NB-1:0]     pnum, pq;
      logic [DB:0]       prem, rem_sh;
      logic [DB-1:0]     pdv;
      logic [SIDE_W-1:0] pside;
      logic              ge;

      if (i == 0) begin : g_first
         assign pv    = in_valid;
         assign pnum  = in_num;
         assign prem  = '0;
         assign pq    = '0;
         assign pdv   = in_dv;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = v_ff[i-1];
         assign pnum  = num_ff[i-1];
         assign prem  = rem_ff[i-1];
         assign pq    = q_ff[i-1];
         assign pdv   = dv_ff[i-1];
         assign pside = side_ff[i-1];
      end

      assign rem_sh = {prem[DB-1:0], pnum[NB-1]};
      assign ge     = rem_sh >= {1'b0, pdv};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= pv;
         end
         if (en) begin
            num_ff[i]  <= pnum << 1;
            rem_ff[i]  <= ge ? rem_sh - {1'b0, pdv} : rem_sh;
            q_ff[i]    <= {pq[NB-2:0], ge};
            dv_ff[i]   <= pdv;
            side_ff[i] <= pside;
         end
      end
   end

   assign out_valid = v_ff[NB-1];
   assign out_q     = q_ff[NB-1];
   assign out_dv    = dv_ff[NB-1];
   assign out_side  = side_ff[NB-1];

endmodule

`default_nettype wire

// ----- hdl/ogive_profile_point_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// ogive_profile_point_evaluator_core
// Tangent ogive profile: radius and saturated slope for each axial position.
// ----------------------------------------------------------------------------
//  port group | dir | beat contents
//  req        | in  | x (unsigned fixed point)
//  rsp        | out | y, slope (signed fixed point), status
//  csr_*      | in  | APB writes/reads of curve radius (0x0), base diameter (0x4)
//
//  One beat per cycle sustained while rsp is not held and no length update
//  runs. Three front stages, one stage per root bit, one per quotient bit,
//  one output register. After each CSR write req.ready stays low while the
//  length root iterates. Reset is synchronous; it clears valids and CSRs.
//  A held rsp beat freezes the whole pipe; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module ogive_profile_point_evaluator_core #(
   parameter int FRAC_BITS = ogpe_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = ogpe_pkg::WORD_BITS_DEF,
   parameter int AW        = (WORD_BITS > 32) ? 4 : 3,
   parameter int DW        = (WORD_BITS > 32) ? 64 : 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   ogpe_req_if.sink           req,
   ogpe_rsp_if.source         rsp,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [AW-1:0] csr_paddr,
   input  wire logic [DW-1:0] csr_pwdata,
   output logic [DW-1:0]      csr_prdata,
   output logic               csr_pready
);
   import ogpe_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int K  = W + 1;
   localparam int NB = W + FRAC_BITS + 1;
   localparam int SW = W + 3;
   localparam int YW = W + 3;

   logic [W-1:0]   rho, diam, len;
   logic [2*W-1:0] rr;
   cfg_status_type cfg_st;
   logic           adv;

   ogpe_cfg #(.WORD_BITS(W), .AW(AW), .DW(DW)) u_cfg (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready,
      .rho, .diam, .len, .rr, .status(cfg_st)
   );

   // front stages
   logic           v1_ff, v2_ff, v3_ff;
   logic [W-1:0]   ad1_ff, ad2_ff, ad3_ff;
   logic           neg1_ff, neg2_ff, neg3_ff;
   logic [1:0]     code1_ff, code2_ff, code3_ff;
   logic [2*W-1:0] dd2_ff;
   logic [2*K-1:0] rad3_ff;
   logic           x_le;

   assign adv       = ~rsp.valid | rsp.ready;
   assign req.ready = adv & ~cfg_st.busy;
   assign x_le      = len >= req.x;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid & ~cfg_st.busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (adv) begin
         ad1_ff   <= x_le ? len - req.x : req.x - len;
         neg1_ff  <= ~x_le;
         code1_ff <= cfg_st.length_valid ? STATUS_OK : STATUS_BAD_CFG;
         dd2_ff   <= {{W{1'b0}}, ad1_ff} * {{W{1'b0}}, ad1_ff};
         ad2_ff   <= ad1_ff;
         neg2_ff  <= neg1_ff;
         code2_ff <= code1_ff;
         rad3_ff  <= (dd2_ff > rr) ? '0 : {rr - dd2_ff, 2'b00};
         ad3_ff   <= ad2_ff;
         neg3_ff  <= neg2_ff;
         if (code2_ff == STATUS_BAD_CFG) begin
            code3_ff <= STATUS_BAD_CFG;
         end else if (dd2_ff > rr) begin
            code3_ff <= STATUS_OFF_CURVE;
         end else begin
            code3_ff <= STATUS_OK;
         end
      end
   end

   logic          sq_valid;
   logic [K-1:0]  sq_root;
   logic [SW-1:0] sq_side;

   ogpe_sqrt_pipe #(.K(K), .SIDE_W(SW)) u_sqrt (
      .clock, .reset, .en(adv),
      .in_valid(v3_ff), .in_rad(rad3_ff), .in_side({ad3_ff, neg3_ff, code3_ff}),
      .out_valid(sq_valid), .out_root(sq_root), .out_side(sq_side)
   );

   logic          dv_valid;
   logic [NB-1:0] dv_q;
   logic [K-1:0]  s2;
   logic [2:0]    dv_side;

   ogpe_div_pipe #(.NB(NB), .DB(K), .SIDE_W(3)) u_div (
      .clock, .reset, .en(adv),
      .in_valid(sq_valid),
      .in_num({sq_side[SW-1:3], {(FRAC_BITS+1){1'b0}}}),
      .in_dv(sq_root), .in_side(sq_side[2:0]),
      .out_valid(dv_valid), .out_q(dv_q), .out_dv(s2), .out_side(dv_side)
   );

   // output stage
   logic signed [YW-1:0] y2;
   logic [W-1:0]         half, limit, mag, slope_val;
   logic                 neg;
   logic [1:0]           code;
   logic                 rsp_valid_ff;
   logic [W:0]           rsp_y_ff;
   logic [W-1:0]         rsp_slope_ff;
   logic [1:0]           rsp_status_ff;

   assign neg       = dv_side[2];
   assign code      = dv_side[1:0];
   assign y2        = $signed({2'b00, s2}) + $signed({3'b000, diam})
                      - $signed({2'b00, rho, 1'b0});
   assign half      = {1'b1, {(W-1){1'b0}}};
   assign limit     = neg ? half : half - 1'b1;
   assign mag       = (dv_q > NB'(limit)) ? limit : dv_q[W-1:0];
   assign slope_val = neg ? -mag : mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
      if (adv) begin
         if (code != STATUS_OK) begin
            rsp_y_ff      <= '0;
            rsp_slope_ff  <= '0;
            rsp_status_ff <= code;
         end else if (s2 == '0) begin
            rsp_y_ff      <= y2[W+1:1];
            rsp_slope_ff  <= limit;
            rsp_status_ff <= STATUS_INF_SLOPE;
         end else begin
            rsp_y_ff      <= y2[W+1:1];
            rsp_slope_ff  <= slope_val;
            rsp_status_ff <= STATUS_OK;
         end
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.y      = rsp_y_ff;
   assign rsp.slope  = rsp_slope_ff;
   assign rsp.status = rsp_status_ff;

endmodule

`default_nettype wire

// ----- hdl/ogpe_checker.sv -----
// ----------------------------------------------------------------------------
// ogpe_checker
// Port-level assertions for the ogive profile evaluator, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module ogpe_checker #(
   parameter int WORD_BITS = ogpe_pkg::WORD_BITS_DEF
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [WORD_BITS:0]   rsp_y,
   input wire logic [WORD_BITS-1:0] rsp_slope,
   input wire logic [1:0]           rsp_status,
   input wire logic                 csr_psel,
   input wire logic                 csr_penable,
   input wire logic                 csr_pwrite
);
   import ogpe_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_y) && $stable(rsp_slope)
      && $stable(rsp_status))
      else $error("rsp beat changed while stalled");

   a_busy_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite |=> !req_ready)
      else $error("req accepted while length is recomputed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_BAD_CFG || rsp_status == STATUS_OFF_CURVE)
      |-> rsp_y == '0 && rsp_slope == '0)
      else $error("fault beat carries nonzero result");

endmodule

bind ogive_profile_point_evaluator_core ogpe_checker #(.WORD_BITS(WORD_BITS)) u_ogpe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_y      (rsp.y),
   .rsp_slope  (rsp.slope),
   .rsp_status (rsp.status),
   .csr_psel   (csr_psel),
   .csr_penable(csr_penable),
   .csr_pwrite (csr_pwrite)
);

`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ogive profile point evaluator. A bit-exact
// predictor computes radius, slope and status for every accepted x beat;
// a checker compares each rsp beat against the oldest prediction. Covers
// the unconfigured state, geometry extremes, random shapes and back pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import ogpe_pkg::*;

   localparam int WB = 32;
   localparam int FB = 16;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam logic [2:0] ADDR_RADIUS   = 3'(4 * REG_RHO);
   localparam logic [2:0] ADDR_DIAMETER = 3'(4 * REG_DIAM);

   typedef struct packed {
      logic [WB:0]   y;
      logic [WB-1:0] slope;
      logic [1:0]    status;
   } profile_point_t;

   logic clock;
   logic reset;
   logic          csr_psel, csr_penable, csr_pwrite;
   logic [2:0]    csr_paddr;
   logic [31:0]   csr_pwdata, csr_prdata;
   logic          csr_pready;

   ogpe_req_if #(.WORD_BITS(WB)) req_ch ();
   ogpe_rsp_if #(.WORD_BITS(WB)) rsp_ch ();

   ogive_profile_point_evaluator_core uut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // shadow of configuration and derived length
   logic [WB-1:0] radius_q, diameter_q, length_q;
   logic          length_ok;

   profile_point_t expected_points[$];
   int mismatches, stray_beats, points_sent, points_checked, cfg_writes;
   int status_seen[4];
   bit sender_idle_on, receiver_idle_on;
   int receiver_hold;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] floor_root(logic [127:0] n);
      logic [63:0]  r;
      logic [63:0]  t;
      logic [127:0] sq;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (64'd1 << b);
         sq = {64'd0, t} * {64'd0, t};
         if (sq <= n) r = t;
      end
      return r;
   endfunction

   function automatic void update_length();
      logic [127:0] four_rho;
      four_rho = {94'd0, radius_q, 2'b00};
      if (four_rho >= {96'd0, diameter_q}) begin
         length_ok = 1'b1;
         length_q  = WB'(floor_root({96'd0, diameter_q} * (four_rho - {96'd0, diameter_q}))
                         >> 1);
      end else begin
         length_ok = 1'b0;
         length_q  = '0;
      end
   endfunction

   function automatic profile_point_t predict_point(logic [WB-1:0] x);
      profile_point_t p;
      logic [WB-1:0]  ad;
      logic           neg;
      logic [127:0]   rr, dd, quo, lim;
      logic [63:0]    s2;
      longint         y2;
      p = '0;
      if (!length_ok) begin
         p.status = STATUS_BAD_CFG;
         return p;
      end
      neg = (x > length_q);
      ad  = neg ? x - length_q : length_q - x;
      rr  = {96'd0, radius_q} * {96'd0, radius_q};
      dd  = {96'd0, ad} * {96'd0, ad};
      if (dd > rr) begin
         p.status = STATUS_OFF_CURVE;
         return p;
      end
      s2 = floor_root((rr - dd) << 2);
      y2 = longint'(s2) + longint'(diameter_q) - 2 * longint'(radius_q);
      y2 = y2 >>> 1;
      p.y = y2[WB:0];
      if (s2 == 0) begin
         p.slope  = neg ? {1'b1, {(WB-1){1'b0}}} : {1'b0, {(WB-1){1'b1}}};
         p.status = STATUS_INF_SLOPE;
         return p;
      end
      quo = ({96'd0, ad} << (FB + 1)) / {64'd0, s2};
      lim = neg ? (128'd1 << (WB - 1)) : (128'd1 << (WB - 1)) - 1;
      if (quo > lim) quo = lim;
      p.slope  = neg ? WB'(-quo) : WB'(quo);
      p.status = STATUS_OK;
      return p;
   endfunction

   // receiver: random stalls plus an optional long hold-off
   int stall_left;
   initial begin
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (receiver_hold > 0) begin
            receiver_hold--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      profile_point_t got, exp_p;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.y = rsp_ch.y;
         got.slope = rsp_ch.slope;
         got.status = rsp_ch.status;
         if (receiver_idle_on) stall_left = $urandom_range(0, 3);
         if (expected_points.size() == 0) begin
            stray_beats++;
            if (stray_beats + mismatches <= 10)
               $display("unexpected rsp beat: y=%h slope=%h status=%0d",
                        got.y, got.slope, got.status);
         end else begin
            exp_p = expected_points.pop_front();
            points_checked++;
            status_seen[got.status]++;
            if (got !== exp_p) begin
               mismatches++;
               if (mismatches + stray_beats <= 10)
                  $display("mismatch: exp y=%h slope=%h st=%0d got y=%h slope=%h st=%0d",
                           exp_p.y, exp_p.slope, exp_p.status,
                           got.y, got.slope, got.status);
            end
         end
      end
   end

   // watchdog on beats in either direction
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d results outstanding", expected_points.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_position(input logic [WB-1:0] x);
      int gap;
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.x     <= x;
      do @(posedge clock); while (!req_ch.ready);
      expected_points.push_back(predict_point(x));
      points_sent++;
      gap = sender_idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= addr; csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == ADDR_RADIUS) radius_q = data;
      else diameter_q = data;
      update_length();
      cfg_writes++;
   endtask

   task automatic set_shape(input logic [31:0] rho, input logic [31:0] dia);
      drain();
      csr_write(ADDR_RADIUS, rho);
      csr_write(ADDR_DIAMETER, dia);
   endtask

   function automatic logic [WB-1:0] x_on_curve();
      logic [63:0] lo, hi, span;
      lo = (length_q > radius_q) ? length_q - radius_q : 0;
      hi = 64'(length_q) + 64'(radius_q);
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      span = hi - lo + 1;
      case ($urandom_range(0, 7))
         0: return WB'(lo);
         1: return WB'(hi);
         2: return $urandom;
         default: return WB'(lo + ({$urandom, $urandom} % span));
      endcase
   endfunction

   task automatic test_unconfigured();
      send_position('0);
      send_position('1);
      send_position(32'h0001_0000);
   endtask

   task automatic test_directed();
      set_shape(32'h000A_0000, 32'h0004_0000);    // rho 10, Rb 2, L 6
      send_position(32'h0000_0000);
      send_position(32'h0006_0000);
      send_position(32'h0010_0000);               // d = -rho, zero denominator
      send_position(32'h000F_FFFF);               // steep, short of saturation
      send_position(32'h0010_0001);               // just off curve
      send_position(32'hFFFF_FFFF);
      set_shape(32'h0005_0000, 32'h000A_0000);    // L equals rho
      send_position(32'h0000_0000);               // d = +rho, zero denominator
      send_position(32'h0000_0001);
      set_shape(32'h0001_0000, 32'h0004_0001);    // 4 rho < D
      send_position(32'h0000_8000);
      set_shape('0, '0);
      send_position('0);
      send_position(32'h0000_0001);
      set_shape('1, '0);
      send_position('0);
      send_position('1);
      set_shape('1, '1);
      send_position('0);
      send_position(32'h8000_0000);
      send_position('1);
      set_shape(32'h4000_0000, '1);
      send_position('0);
      send_position(32'h7FFF_FFFF);
   endtask

   task automatic test_random_shapes();
      logic [31:0] rho, dia;
      logic [33:0] four_rho;
      for (int phase = 0; phase < 20; phase++) begin
         case (phase % 4)
            0: rho = $urandom_range(1, 32'h00FF_FFFF);
            1: rho = $urandom;
            2: rho = $urandom_range(1, 32'h0000_FFFF);
            default: rho = $urandom_range(0, 32'h0100_0000);
         endcase
         four_rho = {rho, 2'b00};
         if (phase % 7 == 6) dia = $urandom;
         else if (four_rho > 34'hFFFF_FFFF) dia = $urandom;
         else dia = 32'({$urandom, $urandom} % (64'(four_rho) + 1));
         set_shape(rho, dia);
         sender_idle_on   = (phase % 5 != 3);
         receiver_idle_on = (phase % 5 != 2);
         for (int i = 0; i < 50; i++) send_position(x_on_curve());
      end
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
   endtask

   task automatic test_back_pressure();
      set_shape(32'h0020_0000, 32'h0018_0000);
      receiver_hold = 400;
      sender_idle_on = 1'b0;
      for (int i = 0; i < 150; i++) send_position(x_on_curve());
      sender_idle_on = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0; req_ch.x = '0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      radius_q = '0; diameter_q = '0; length_q = '0; length_ok = 1'b0;
      mismatches = 0; stray_beats = 0; points_sent = 0; points_checked = 0;
      cfg_writes = 0; receiver_hold = 0; quiet_cycles = 0;
      sender_idle_on = 1'b1; receiver_idle_on = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unconfigured();
      test_directed();
      test_random_shapes();
      test_back_pressure();
      drain();

      $display("sent %0d positions over %0d register writes, checked %0d points",
               points_sent, cfg_writes, points_checked);
      $display("status mix ok/bad_cfg/off_curve/inf_slope: %0d/%0d/%0d/%0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (mismatches == 0 && stray_beats == 0 && expected_points.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("mismatches %0d, unexpected beats %0d, missing %0d",
                  mismatches, stray_beats, expected_points.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
